// ===== src/pte_pkg.sv =====
// Shared types and codes for the postfix trigger evaluator.
package pte_pkg;

  // Fixed field widths of the channels and registers.
  localparam int HITS_W        = 32;
  localparam int TARGET_W      = 16;
  localparam int TOKEN_COUNT_W = 5;
  localparam int TOKEN_W       = 6;
  localparam int TOKENS_LOW_W  = 60;
  localparam int TOKENS_HIGH_W = 36;
  localparam int TOKENS_ALL_W  = TOKENS_LOW_W + TOKENS_HIGH_W;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 60;
  localparam int HIT_COUNT_W   = 16;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE      = 3'd0,
    REG_TARGET      = 3'd1,
    REG_TOKEN_COUNT = 3'd2,
    REG_TOKENS_LOW  = 3'd3,
    REG_TOKENS_HIGH = 3'd4
  } pte_reg_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_UPDATE
  } pte_state_t;

  // Token classes after decode.
  typedef enum logic [1:0] {
    TK_PUSH,
    TK_AND,
    TK_OR,
    TK_FALSE
  } pte_tok_class_t;

  typedef logic [TOKEN_W-1:0] pte_token_t;

  // Configuration as seen by the sequencer; token count already clamped.
  typedef struct packed {
    logic                     enable;
    logic [TARGET_W-1:0]      target_count;
    logic [TOKEN_COUNT_W-1:0] token_count;
  } pte_cfg_t;

  // Commands from the sequencer to the stack unit.
  typedef struct packed {
    logic clear;
    logic step;
  } pte_alu_ctrl_t;

  // Status from the stack unit.
  typedef struct packed {
    logic top;
    logic depth_one;
    logic error;
  } pte_alu_stat_t;

endpackage

// ===== src/pte_cfg_regs.sv =====
// Configuration registers and the token read port.
module pte_cfg_regs
  import pte_pkg::*;
#(
  parameter int MAX_TOKENS = 16,
  parameter int TOK_IDX_W  = $clog2(MAX_TOKENS)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [TOK_IDX_W-1:0]  tok_idx,
  output pte_token_t            token,
  output pte_cfg_t              cfg
);

  logic                     enable_r;
  logic [TARGET_W-1:0]      target_count_r;
  logic [TOKEN_COUNT_W-1:0] token_count_r;
  logic [TOKENS_LOW_W-1:0]  tokens_low_r;
  logic [TOKENS_HIGH_W-1:0] tokens_high_r;
  logic [TOKENS_ALL_W-1:0]  tok_vec;
  pte_token_t               tok_arr [MAX_TOKENS];

  // Writes are always taken; an unknown index is ignored.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r       <= 1'b0;
      target_count_r <= '0;
      token_count_r  <= '0;
      tokens_low_r   <= '0;
      tokens_high_r  <= '0;
    end else if (cfg_valid) begin
      unique case (pte_reg_t'(cfg_index))
        REG_ENABLE:      enable_r       <= cfg_wdata[0];
        REG_TARGET:      target_count_r <= cfg_wdata[TARGET_W-1:0];
        REG_TOKEN_COUNT: token_count_r  <= cfg_wdata[TOKEN_COUNT_W-1:0];
        REG_TOKENS_LOW:  tokens_low_r   <= cfg_wdata[TOKENS_LOW_W-1:0];
        REG_TOKENS_HIGH: tokens_high_r  <= cfg_wdata[TOKENS_HIGH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Token slots in program order, token 0 in the low bits.
  assign tok_vec = {tokens_high_r, tokens_low_r};

  for (genvar g = 0; g < MAX_TOKENS; g++) begin : g_tok
    assign tok_arr[g] = tok_vec[g*TOKEN_W +: TOKEN_W];
  end

  assign token = tok_arr[tok_idx];

  // A count above the program capacity runs the whole program.
  always_comb begin
    cfg.enable       = enable_r;
    cfg.target_count = target_count_r;
    if (token_count_r > TOKEN_COUNT_W'(MAX_TOKENS)) begin
      cfg.token_count = TOKEN_COUNT_W'(MAX_TOKENS);
    end else begin
      cfg.token_count = token_count_r;
    end
  end

endmodule

// ===== src/pte_stack_alu.sv =====
// One-bit evaluation stack; executes one postfix token per step.
module pte_stack_alu
  import pte_pkg::*;
#(
  parameter int MAX_TOKENS      = 16,
  parameter int NUM_BREAKPOINTS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pte_alu_ctrl_t     ctrl,
  input  pte_token_t        token,
  input  logic [HITS_W-1:0] hits,
  output pte_alu_stat_t     stat
);

  localparam int DEPTH_W = $clog2(MAX_TOKENS + 1);

  logic [MAX_TOKENS-1:0] stack_r, stack_nxt;
  logic [DEPTH_W-1:0]    depth_r, depth_nxt;
  logic                  err_r, err_nxt;
  pte_tok_class_t        tclass;
  logic                  op_bit;

  // Token decode against the breakpoint count.
  always_comb begin
    if (token < TOKEN_W'(NUM_BREAKPOINTS)) begin
      tclass = TK_PUSH;
    end else if (token == TOKEN_W'(NUM_BREAKPOINTS)) begin
      tclass = TK_AND;
    end else if (token == TOKEN_W'(NUM_BREAKPOINTS + 1)) begin
      tclass = TK_OR;
    end else begin
      tclass = TK_FALSE;
    end
  end

  // Operator result from the two top entries.
  always_comb begin
    unique case (tclass)
      TK_AND:  op_bit = stack_r[0] & stack_r[1];
      TK_OR:   op_bit = stack_r[0] | stack_r[1];
      default: op_bit = 1'b0;
    endcase
  end

  // One step: push a hit bit, or pop two and push the result.
  // Once an underflow is seen the stack freezes.
  always_comb begin
    stack_nxt = stack_r;
    depth_nxt = depth_r;
    err_nxt   = err_r;
    if (ctrl.clear) begin
      stack_nxt = '0;
      depth_nxt = '0;
      err_nxt   = 1'b0;
    end else if (ctrl.step && !err_r) begin
      if (tclass == TK_PUSH) begin
        stack_nxt = {stack_r[MAX_TOKENS-2:0], hits[token[4:0]]};
        depth_nxt = depth_r + DEPTH_W'(1);
      end else if (depth_r < DEPTH_W'(2)) begin
        err_nxt = 1'b1;
      end else begin
        stack_nxt = {1'b0, stack_r[MAX_TOKENS-1:2], op_bit};
        depth_nxt = depth_r - DEPTH_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
      err_r   <= 1'b0;
    end else begin
      depth_r <= depth_nxt;
      err_r   <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stack_r <= stack_nxt;
  end

  assign stat.top       = stack_r[0];
  assign stat.depth_one = (depth_r == DEPTH_W'(1));
  assign stat.error     = err_r;

endmodule

// ===== src/pte_seq.sv =====
// Sequencer: takes an item, walks the program, updates the hit counter
// and loads the result register.
module pte_seq
  import pte_pkg::*;
#(
  parameter int MAX_TOKENS  = 16,
  parameter int COUNT_WIDTH = 16,
  parameter int TOK_IDX_W   = $clog2(MAX_TOKENS)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [HITS_W-1:0]      in_breakpoint_hits,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_break_hit,
  output logic                   out_expr_error,
  output logic [HIT_COUNT_W-1:0] out_hit_count,
  input  pte_cfg_t               cfg,
  output logic [TOK_IDX_W-1:0]   tok_idx,
  output pte_alu_ctrl_t          alu_ctrl,
  input  pte_alu_stat_t          alu_stat,
  output logic [HITS_W-1:0]      hits
);

  localparam int CMP_W = (COUNT_WIDTH > TARGET_W) ? COUNT_WIDTH : TARGET_W;

  pte_state_t               state_r, state_nxt;
  logic [TOK_IDX_W-1:0]     idx_r, idx_nxt;
  logic [HITS_W-1:0]        hits_r, hits_nxt;
  logic [COUNT_WIDTH-1:0]   cnt_r, cnt_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic                     out_brk_r, out_err_r;
  logic [HIT_COUNT_W-1:0]   out_cnt_r;
  logic                     out_free, out_load;
  logic                     last_tok;
  logic                     err_fin, brk_fin;
  logic [COUNT_WIDTH-1:0]   cnt_inc, cnt_fin;

  assign out_free = !out_valid_r || !out_stall;
  assign last_tok = ((TOKEN_COUNT_W'(idx_r) + TOKEN_COUNT_W'(1)) == cfg.token_count);

  // Final verdict once the program has run.
  always_comb begin
    cnt_inc = cnt_r;
    if (alu_stat.top && (cnt_r != '1)) begin
      cnt_inc = cnt_r + COUNT_WIDTH'(1);
    end
    err_fin = cfg.enable && (alu_stat.error || !alu_stat.depth_one);
    brk_fin = cfg.enable && !err_fin &&
              (CMP_W'(cfg.target_count) == CMP_W'(cnt_inc));
    if (!cfg.enable || err_fin) begin
      cnt_fin = cnt_r;
    end else if (brk_fin) begin
      cnt_fin = '0;
    end else begin
      cnt_fin = cnt_inc;
    end
  end

  // Next state and control.
  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    hits_nxt       = hits_r;
    cnt_nxt        = cnt_r;
    in_stall       = 1'b1;
    alu_ctrl.clear = 1'b0;
    alu_ctrl.step  = 1'b0;
    out_load       = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          hits_nxt       = in_breakpoint_hits;
          idx_nxt        = '0;
          alu_ctrl.clear = 1'b1;
          if (cfg.enable && (cfg.token_count != '0)) begin
            state_nxt = ST_EVAL;
          end else begin
            state_nxt = ST_UPDATE;
          end
        end
      end
      ST_EVAL: begin
        alu_ctrl.step = 1'b1;
        if (last_tok || alu_stat.error) begin
          state_nxt = ST_UPDATE;
        end else begin
          idx_nxt = idx_r + TOK_IDX_W'(1);
        end
      end
      ST_UPDATE: begin
        if (out_free) begin
          out_load  = 1'b1;
          cnt_nxt   = cnt_fin;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Result register handshake.
  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hits_r <= hits_nxt;
    if (out_load) begin
      out_brk_r <= brk_fin;
      out_err_r <= err_fin;
      out_cnt_r <= HIT_COUNT_W'(cnt_fin);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_break_hit  = out_brk_r;
  assign out_expr_error = out_err_r;
  assign out_hit_count  = out_cnt_r;
  assign tok_idx        = idx_r;
  assign hits           = hits_r;

  // A firing and an error never come together.
  a_brk_err_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_brk_r && out_err_r))
    else $error("break and error reported together");

  // A firing always leaves the counter cleared.
  a_brk_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_brk_r) |-> (out_cnt_r == '0))
    else $error("break reported with nonzero count");

  // An error result leaves the counter untouched.
  a_err_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && err_fin) |=> (cnt_r == $past(cnt_r)))
    else $error("counter changed on an error");

  // The program walk never runs past the token count.
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EVAL) |-> (TOKEN_COUNT_W'(idx_r) < cfg.token_count))
    else $error("token index past program end");

endmodule

// ===== src/postfix_trigger_evaluator_core.sv =====
// Channel  Direction  Handshake           Payload
// in       input      in_valid/in_stall   in_breakpoint_hits[31:0]
// out      output     out_valid/out_stall out_break_hit, out_expr_error,
//                                         out_hit_count[15:0]
// cfg      input      cfg_valid/cfg_ready cfg_index[2:0], cfg_wdata[59:0]
//
// An item is accepted, then walks its n tokens, where n is the token count
// (clamped to MAX_TOKENS; zero when disabled), one token per step in the
// shared one-bit stack unit, and then takes the counter update.
// An underflow ends the token walk early. The next item is accepted in the
// cycle after the update. A stalled result holds the update step until the
// result register frees. Reset clears the configuration and the hit counter.
module postfix_trigger_evaluator_core
  import pte_pkg::*;
#(
  parameter int MAX_TOKENS      = 16,
  parameter int NUM_BREAKPOINTS = 32,
  parameter int COUNT_WIDTH     = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [HITS_W-1:0]      in_breakpoint_hits,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_break_hit,
  output logic                   out_expr_error,
  output logic [HIT_COUNT_W-1:0] out_hit_count,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int TOK_IDX_W = $clog2(MAX_TOKENS);

  pte_cfg_t             cfg;
  pte_token_t           token;
  logic [TOK_IDX_W-1:0] tok_idx;
  pte_alu_ctrl_t        alu_ctrl;
  pte_alu_stat_t        alu_stat;
  logic [HITS_W-1:0]    hits;

  // Register file and token select.
  pte_cfg_regs #(
    .MAX_TOKENS (MAX_TOKENS),
    .TOK_IDX_W  (TOK_IDX_W)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .tok_idx   (tok_idx),
    .token     (token),
    .cfg       (cfg)
  );

  // Shared stack unit.
  pte_stack_alu #(
    .MAX_TOKENS      (MAX_TOKENS),
    .NUM_BREAKPOINTS (NUM_BREAKPOINTS)
  ) u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (alu_ctrl),
    .token (token),
    .hits  (hits),
    .stat  (alu_stat)
  );

  // Sequencer, hit counter and result register.
  pte_seq #(
    .MAX_TOKENS  (MAX_TOKENS),
    .COUNT_WIDTH (COUNT_WIDTH),
    .TOK_IDX_W   (TOK_IDX_W)
  ) u_seq (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_breakpoint_hits (in_breakpoint_hits),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_break_hit      (out_break_hit),
    .out_expr_error     (out_expr_error),
    .out_hit_count      (out_hit_count),
    .cfg                (cfg),
    .tok_idx            (tok_idx),
    .alu_ctrl           (alu_ctrl),
    .alu_stat           (alu_stat),
    .hits               (hits)
  );

endmodule
